// File: hdl/rhc_pkg.sv
`timescale 1ns / 1ps
package rhc_pkg;

    localparam int RGB_W  = 8;
    localparam int HUE_W  = 15;
    localparam int SAT_W  = 17;
    localparam int SUM_W  = 9;
    localparam int NUM_W  = 11;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [RGB_W-1:0] delta;
        logic [RGB_W-1:0] denom;
        logic [NUM_W-1:0] num;
        logic             grey;
    } prep_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             grey;
    } side_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] sat;
        logic [SUM_W-1:0] sum;
        logic             grey;
    } res_t;

    typedef struct packed {
        logic en;
        logic load_out;
        logic out_from_skid;
        logic load_skid;
    } ctl_t;

endpackage

// File: hdl/rhc_prep.sv
`timescale 1ns / 1ps
module rhc_prep
(
    input  logic                       clk,
    input  logic                       en,
    input  logic [rhc_pkg::RGB_W-1:0]  red,
    input  logic [rhc_pkg::RGB_W-1:0]  green,
    input  logic [rhc_pkg::RGB_W-1:0]  blue,
    output rhc_pkg::prep_t             prep
);
    import rhc_pkg::*;

    prep_t            prep_reg;
    prep_t            prep_next;
    logic             red_max;
    logic             green_max;
    logic [RGB_W-1:0] hi;
    logic [RGB_W-1:0] lo;
    logic [SUM_W-1:0] sum;
    logic [RGB_W-1:0] delta;
    logic [NUM_W-1:0] dx;

    always_comb
    begin
        // red wins ties, then green
        red_max   = (red >= green) && (red >= blue);
        green_max = !red_max && (green >= blue);
        if (red_max)
        begin
            hi = red;
        end
        else if (green_max)
        begin
            hi = green;
        end
        else
        begin
            hi = blue;
        end
        lo = red;
        if (green < lo)
        begin
            lo = green;
        end
        if (blue < lo)
        begin
            lo = blue;
        end
        sum   = SUM_W'(hi) + SUM_W'(lo);
        delta = hi - lo;
        dx    = NUM_W'(delta);

        prep_next.sum   = sum;
        prep_next.delta = delta;
        prep_next.grey  = (delta == '0);
        if (sum > SUM_W'(255))
        begin
            prep_next.denom = RGB_W'(SUM_W'(510) - sum);
        end
        else
        begin
            prep_next.denom = RGB_W'(sum);
        end

        // sector offset in units of delta, sixths of the circle
        if (red_max)
        begin
            if (green >= blue)
            begin
                prep_next.num = NUM_W'(green) - NUM_W'(blue);
            end
            else
            begin
                prep_next.num = (dx * NUM_W'(6)) + NUM_W'(green) - NUM_W'(blue);
            end
        end
        else if (green_max)
        begin
            prep_next.num = (dx * NUM_W'(2)) + NUM_W'(blue) - NUM_W'(red);
        end
        else
        begin
            prep_next.num = (dx * NUM_W'(4)) + NUM_W'(red) - NUM_W'(green);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_reg <= prep_next;
        end
    end

    assign prep = prep_reg;

endmodule

// File: hdl/rhc_div.sv
`timescale 1ns / 1ps
module rhc_div
#(
    parameter int QB = 17
)
(
    input  logic                       clk,
    input  logic                       en,
    input  logic [QB+rhc_pkg::RGB_W-1:0] dividend,
    input  logic [rhc_pkg::RGB_W-1:0]  divisor,
    output logic [QB-1:0]              quotient
);
    import rhc_pkg::*;

    localparam int DW = QB + RGB_W;

    // working word: partial remainder on top, dividend bits then quotient bits below
    logic [DW-1:0]    w_reg [QB+1];
    logic [RGB_W-1:0] d_reg [QB+1];
    logic [DW-1:0]    w_next [QB];

    genvar k;
    generate
        for (k = 0; k < QB; k++)
        begin : g_step
            logic [RGB_W:0] shifted;
            logic [RGB_W:0] diff;
            logic           qbit;

            always_comb
            begin
                shifted = {w_reg[k][DW-1:QB], w_reg[k][QB-1]};
                diff    = shifted - {1'b0, d_reg[k]};
                qbit    = (shifted >= {1'b0, d_reg[k]});
                if (qbit)
                begin
                    w_next[k] = {diff[RGB_W-1:0], w_reg[k][QB-2:0], 1'b1};
                end
                else
                begin
                    w_next[k] = {shifted[RGB_W-1:0], w_reg[k][QB-2:0], 1'b0};
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg[0] <= dividend;
            d_reg[0] <= divisor;
            for (int i = 0; i < QB; i++)
            begin
                w_reg[i+1] <= w_next[i];
                d_reg[i+1] <= d_reg[i];
            end
        end
    end

    assign quotient = w_reg[QB][QB-1:0];

endmodule

// File: hdl/rhc_ctl.sv
`timescale 1ns / 1ps
module rhc_ctl
#(
    parameter int NS = 19
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          out_stall,
    output logic          in_stall,
    output logic          out_valid,
    output rhc_pkg::ctl_t ctl
);
    import rhc_pkg::*;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          skid_valid_reg;
    logic          skid_valid_next;
    logic          out_take;
    logic          leaving;

    always_comb
    begin
        ctl.en            = !skid_valid_reg;
        out_take          = !out_valid_reg || !out_stall;
        leaving           = valid_reg[NS-1] && ctl.en;
        ctl.load_out      = out_take && (skid_valid_reg || leaving);
        ctl.out_from_skid = skid_valid_reg;
        ctl.load_skid     = leaving && !out_take;

        out_valid_next  = out_take ? (skid_valid_reg || leaving) : 1'b1;
        skid_valid_next = skid_valid_reg ? !out_take : ctl.load_skid;

        if (ctl.en)
        begin
            valid_next = {valid_reg[NS-2:0], in_valid};
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;

    // the skid only fills behind a result that is already being held
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item while the output is empty");

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && out_stall |=> skid_valid_reg && out_valid_reg)
        else $error("skid item dropped under stall");

    a_frozen_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |=> $stable(valid_reg))
        else $error("pipeline moved while the skid was full");

endmodule

// File: hdl/rgb_to_hsl_converter_top.sv
`timescale 1ns / 1ps
// RGB to HSL converter: takes one 8-bit RGB pixel per clock on the pixel channel, while
// pixel_stall is low, and returns hue (1/2^HUE_FRACTION_BITS degree), saturation (scaled by
// 2^SAT_FRACTION_BITS, rounded) and lightness as max+min on the hsl channel, one item per
// item in, in order. A pixel passes the prep register, the divider stages and the output
// register, with QB = max(SAT_FRACTION_BITS+1, HUE_FRACTION_BITS+9). The two dividers
// run side by side and retire one quotient bit per pipeline stage. A full pixel per clock
// is sustained while hsl_stall is low; a two-entry output buffer lets the pipeline keep
// moving under hsl_stall until a second result waits behind the held one, and pixel_stall
// is a registered signal that goes high only while that buffer is full.
module rgb_to_hsl_converter_top
#(
    parameter int SAT_FRACTION_BITS = 16,
    parameter int HUE_FRACTION_BITS = 6
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pixel_valid,
    output logic                      pixel_stall,
    input  logic [rhc_pkg::RGB_W-1:0] red,
    input  logic [rhc_pkg::RGB_W-1:0] green,
    input  logic [rhc_pkg::RGB_W-1:0] blue,
    output logic                      hsl_valid,
    input  logic                      hsl_stall,
    output logic [rhc_pkg::HUE_W-1:0] hue,
    output logic [rhc_pkg::SAT_W-1:0] saturation,
    output logic [rhc_pkg::SUM_W-1:0] lightness_sum,
    output logic                      is_grey
);
    import rhc_pkg::*;

    localparam int QB_SAT    = SAT_FRACTION_BITS + 1;
    localparam int QB_HUE    = HUE_FRACTION_BITS + 9;
    localparam int QB        = (QB_SAT > QB_HUE) ? QB_SAT : QB_HUE;
    localparam int DW        = QB + RGB_W;
    localparam int NS        = QB + 2;
    localparam int HUE_SCALE = 60 << HUE_FRACTION_BITS;
    localparam logic [QB-1:0] CIRCLE = QB'(360 << HUE_FRACTION_BITS);

    ctl_t            ctl;
    prep_t           prep;
    logic [DW-1:0]   sat_dividend;
    logic [DW-1:0]   hue_dividend;
    logic [QB-1:0]   sat_q;
    logic [QB-1:0]   hue_q;
    logic [QB-1:0]   hue_wrapped;
    logic [QB+SAT_W-1:0] sat_ext;
    logic [QB+HUE_W-1:0] hue_ext;
    side_t           side_reg [QB+1];
    res_t            result;
    res_t            out_reg;
    res_t            out_next;
    res_t            skid_reg;

    rhc_ctl #(.NS(NS)) u_ctl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel_valid),
        .out_stall (hsl_stall),
        .in_stall  (pixel_stall),
        .out_valid (hsl_valid),
        .ctl       (ctl)
    );

    rhc_prep u_prep
    (
        .clk   (clk),
        .en    (ctl.en),
        .red   (red),
        .green (green),
        .blue  (blue),
        .prep  (prep)
    );

    // rounding terms are folded into the dividends
    assign sat_dividend = (DW'(prep.delta) << SAT_FRACTION_BITS) + DW'(prep.denom >> 1);
    assign hue_dividend = (DW'(HUE_SCALE) * DW'(prep.num)) + DW'(prep.delta >> 1);

    rhc_div #(.QB(QB)) u_div_sat
    (
        .clk      (clk),
        .en       (ctl.en),
        .dividend (sat_dividend),
        .divisor  (prep.denom),
        .quotient (sat_q)
    );

    rhc_div #(.QB(QB)) u_div_hue
    (
        .clk      (clk),
        .en       (ctl.en),
        .dividend (hue_dividend),
        .divisor  (prep.delta),
        .quotient (hue_q)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            side_reg[0].sum  <= prep.sum;
            side_reg[0].grey <= prep.grey;
            for (int i = 0; i < QB; i++)
            begin
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    always_comb
    begin
        hue_wrapped = (hue_q >= CIRCLE) ? (hue_q - CIRCLE) : hue_q;
        sat_ext     = (QB+SAT_W)'(sat_q);
        hue_ext     = (QB+HUE_W)'(hue_wrapped);
        result.sum  = side_reg[QB].sum;
        result.grey = side_reg[QB].grey;
        if (side_reg[QB].grey)
        begin
            result.hue = '0;
            result.sat = '0;
        end
        else
        begin
            result.hue = hue_ext[HUE_W-1:0];
            result.sat = sat_ext[SAT_W-1:0];
        end
        out_next = ctl.out_from_skid ? skid_reg : result;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            out_reg <= out_next;
        end
        if (ctl.load_skid)
        begin
            skid_reg <= result;
        end
    end

    assign hue           = out_reg.hue;
    assign saturation    = out_reg.sat;
    assign lightness_sum = out_reg.sum;
    assign is_grey       = out_reg.grey;

    a_grey_zero: assert property (@(posedge clk) disable iff (!rst_n)
        hsl_valid && is_grey |-> (hue == '0) && (saturation == '0))
        else $error("grey item with nonzero hue or saturation");

    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsl_valid |-> lightness_sum <= SUM_W'(510))
        else $error("lightness sum out of range");

endmodule
